[hw/rtl/walker_min_hop_count_top_macros.svh]
// ----------------------------------------------------------------------------
// walker_min_hop_count_top_macros
// Assertion macros shared by the hop count block.
// ----------------------------------------------------------------------------
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef WALKER_MIN_HOP_COUNT_TOP_MACROS_SVH
`define WALKER_MIN_HOP_COUNT_TOP_MACROS_SVH

// Same-cycle implication.
`define WMHC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define WMHC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/wmhc_pkg.sv]
// ----------------------------------------------------------------------------
// wmhc_pkg
// Shared types, constants and helper functions of the Walker hop count block.
// ----------------------------------------------------------------------------
package wmhc_pkg;

  localparam int ANGLE_FRAC_BITS = 7;
  localparam int HOP_BITS        = 8;
  localparam int ANGLE_W         = 16;
  localparam int TURN_W          = ANGLE_W + 1;
  localparam int LOW_BITS        = ANGLE_FRAC_BITS + 3;
  localparam int DIV_NUM_W       = 18;
  localparam int DIV_DEN_W       = 17;
  localparam int PROD_W          = 32;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_W     = 2;

  localparam logic [TURN_W-1:0]   FULL_TURN = TURN_W'(360 << ANGLE_FRAC_BITS);
  localparam logic [HOP_BITS-1:0] HOP_MAX   = '1;

  // A full turn is 45 * 2^LOW_BITS; the modulo by 45 uses a scaled reciprocal.
  localparam logic [11:0] MOD_BASE  = 12'd45;
  localparam logic [10:0] RECIP_45  = 11'd1456;

  typedef enum logic [1:0] {
    REG_PLANE_SPACING  = 2'd0,
    REG_SLOT_SPACING   = 2'd1,
    REG_PHASING_OFFSET = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] plane_spacing;
    logic [ANGLE_W-1:0] slot_spacing;
    logic [ANGLE_W-1:0] phasing_offset;
  } cfg_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] dist_e;
    logic [ANGLE_W-1:0] dist_w;
    logic [ANGLE_W-1:0] diff;
  } item_t;

  // Reduces a value below two full turns into one turn.
  function automatic logic [ANGLE_W-1:0] wrap(input logic [TURN_W-1:0] x);
    logic [TURN_W-1:0] r;
    r = (x >= FULL_TURN) ? (x - FULL_TURN) : x;
    return r[ANGLE_W-1:0];
  endfunction

  function automatic logic [HOP_BITS-1:0] sat(input logic [DIV_NUM_W-1:0] q);
    return (q > DIV_NUM_W'(HOP_MAX)) ? HOP_MAX : q[HOP_BITS-1:0];
  endfunction

endpackage

[hw/rtl/wmhc_front.sv]
// ----------------------------------------------------------------------------
// wmhc_front
// Input register: takes a word, wraps the angles and forms the RAAN distances
// and the phase difference before handing the item to the queue.
// ----------------------------------------------------------------------------
module wmhc_front import wmhc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ANGLE_W-1:0] src_phase,
  input  logic [ANGLE_W-1:0] src_raan,
  input  logic [ANGLE_W-1:0] dst_phase,
  input  logic [ANGLE_W-1:0] dst_raan,
  input  logic               q_full,
  output logic               push,
  output item_t              push_item
);

  logic  fv;
  item_t fi;
  item_t fi_next;
  logic [ANGLE_W-1:0] sp, sr, dp, dr;

  assign push      = fv & ~q_full;
  assign in_stall  = fv & q_full;
  assign push_item = fi;

  always_comb begin
    sp = wrap({1'b0, src_phase});
    sr = wrap({1'b0, src_raan});
    dp = wrap({1'b0, dst_phase});
    dr = wrap({1'b0, dst_raan});
    fi_next.dist_e = wrap({1'b0, dr} + FULL_TURN - {1'b0, sr});
    fi_next.dist_w = wrap(FULL_TURN - {1'b0, fi_next.dist_e});
    fi_next.diff   = wrap({1'b0, dp} + FULL_TURN - {1'b0, sp});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (!in_stall) begin
      fv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      fi <= fi_next;
    end
  end

endmodule

[hw/rtl/wmhc_queue.sv]
// ----------------------------------------------------------------------------
// wmhc_queue
// Short FIFO that decouples the front register from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module wmhc_queue import wmhc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  item_t mem [0:QUEUE_DEPTH-1];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic do_push, do_pop;

  assign full       = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

[hw/rtl/wmhc_div.sv]
// ----------------------------------------------------------------------------
// wmhc_div
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor, with a side payload carried alongside.
// ----------------------------------------------------------------------------
module wmhc_div import wmhc_pkg::*; #(
  parameter int LANES  = 2,
  parameter int SIDE_W = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [LANES-1:0][DIV_NUM_W-1:0]   num,
  input  logic [DIV_DEN_W-1:0]              den,
  input  logic [SIDE_W-1:0]                 side_in,
  output logic                              out_valid,
  output logic [LANES-1:0][DIV_NUM_W-1:0]   quo,
  output logic [SIDE_W-1:0]                 side_out
);

  localparam int N = DIV_NUM_W;
  localparam int D = DIV_DEN_W;

  logic                          v_s    [1:N];
  logic [D-1:0]                  den_s  [1:N];
  logic [SIDE_W-1:0]             side_s [1:N];
  logic [LANES-1:0][N-1:0]       q_s    [1:N];
  logic [LANES-1:0][N-1:0]       num_s  [1:N-1];
  logic [LANES-1:0][D-1:0]       rem_s  [1:N-1];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic                    v_c;
    logic [D-1:0]            den_c;
    logic [SIDE_W-1:0]       side_c;
    logic [LANES-1:0][N-1:0] num_c, q_c, num_n, q_n;
    logic [LANES-1:0][D-1:0] rem_c, rem_n;

    if (s == 0) begin : g_first
      assign v_c    = in_valid;
      assign den_c  = den;
      assign side_c = side_in;
      assign num_c  = num;
      assign q_c    = '0;
      assign rem_c  = '0;
    end else begin : g_mid
      assign v_c    = v_s[s];
      assign den_c  = den_s[s];
      assign side_c = side_s[s];
      assign num_c  = num_s[s];
      assign q_c    = q_s[s];
      assign rem_c  = rem_s[s];
    end

    always_comb begin
      logic [D:0] trial;
      logic [D:0] sub;
      logic       ge;
      for (int l = 0; l < LANES; l++) begin
        trial    = {rem_c[l], num_c[l][N-1]};
        sub      = trial - {1'b0, den_c};
        ge       = (trial >= {1'b0, den_c});
        rem_n[l] = ge ? sub[D-1:0] : trial[D-1:0];
        num_n[l] = {num_c[l][N-2:0], 1'b0};
        q_n[l]   = {q_c[l][N-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[s+1] <= 1'b0;
      end else if (en) begin
        v_s[s+1] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_s[s+1]  <= den_c;
        side_s[s+1] <= side_c;
        q_s[s+1]    <= q_n;
      end
    end

    if (s < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          num_s[s+1] <= num_n;
          rem_s[s+1] <= rem_n;
        end
      end
    end
  end

  assign out_valid = v_s[N];
  assign quo       = q_s[N];
  assign side_out  = side_s[N];

endmodule

[hw/rtl/wmhc_back.sv]
// ----------------------------------------------------------------------------
// wmhc_back
// Arithmetic pipeline: inter-plane division, phasing product and its modulo,
// intra-plane deltas, intra-plane division and the saturated output register.
// ----------------------------------------------------------------------------
`include "walker_min_hop_count_top_macros.svh"

module wmhc_back import wmhc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                head_valid,
  input  item_t               head_item,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [HOP_BITS-1:0] hops_west,
  output logic [HOP_BITS-1:0] hops_east,
  output logic [HOP_BITS-1:0] up_after_west,
  output logic [HOP_BITS-1:0] up_after_east,
  output logic [HOP_BITS-1:0] down_after_west,
  output logic [HOP_BITS-1:0] down_after_east
);

  // The whole pipeline moves together whenever the output register can move.
  logic adv;
  assign adv = ~out_valid | ~out_stall;
  assign pop = adv & head_valid;

  // Inter-plane division: lane 0 west, lane 1 east.
  logic [1:0][DIV_NUM_W-1:0] num1, quo1;
  logic                      v1;
  logic [ANGLE_W-1:0]        diff1;

  assign num1[0] = {1'b0, head_item.dist_w, 1'b0} + DIV_NUM_W'(cfg.plane_spacing);
  assign num1[1] = {1'b0, head_item.dist_e, 1'b0} + DIV_NUM_W'(cfg.plane_spacing);

  wmhc_div #(.LANES(2), .SIDE_W(ANGLE_W)) u_div_plane (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (head_valid),
    .num      (num1),
    .den      ({cfg.plane_spacing, 1'b0}),
    .side_in  (head_item.diff),
    .out_valid(v1),
    .quo      (quo1),
    .side_out (diff1)
  );

  logic [ANGLE_W-1:0] f;
  assign f = wrap({1'b0, cfg.phasing_offset});

  // Pipeline registers after the first divider.
  logic vn, vp, vf, vr, vs, vd;
  logic [ANGLE_W-1:0] nw_n, ne_n, diff_n;
  logic [ANGLE_W-1:0] nw_p, ne_p, diff_p;
  logic [PROD_W-1:0]  prod_w, prod_e;
  logic [ANGLE_W-1:0] nw_f, ne_f, diff_f;
  logic [11:0]        sw_f, se_f, sw_r, se_r;
  logic [LOW_BITS-1:0] lw_f, le_f, lw_r, le_r;
  logic [6:0]         qw_r, qe_r;
  logic [ANGLE_W-1:0] nw_r, ne_r, diff_r;
  logic [ANGLE_W-1:0] nw_s, ne_s, diff_s, shift_w, shift_e;
  logic [ANGLE_W-1:0] nw_d, ne_d, dw_d, de_d;

  // Folds the bits above the low part modulo 45; 4096 is 1 modulo 45.
  function automatic logic [11:0] fold45(input logic [PROD_W-1:0] p);
    logic [20:0] h;
    logic [12:0] s1;
    h  = p[LOW_BITS+20:LOW_BITS];
    s1 = {1'b0, h[11:0]} + 13'(h[20:12]);
    return s1[11:0] + 12'(s1[12]);
  endfunction

  function automatic logic [6:0] quot45(input logic [11:0] s);
    logic [22:0] m;
    m = 23'(s) * 23'(RECIP_45);
    return m[22:16];
  endfunction

  function automatic logic [5:0] rem45(input logic [11:0] s, input logic [6:0] q);
    logic [11:0] r;
    r = s - 12'(q * MOD_BASE);
    if (r >= MOD_BASE) begin
      r = r - MOD_BASE;
    end
    return r[5:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vn <= 1'b0;
      vp <= 1'b0;
      vf <= 1'b0;
      vr <= 1'b0;
      vs <= 1'b0;
      vd <= 1'b0;
    end else if (adv) begin
      vn <= v1;
      vp <= vn;
      vf <= vp;
      vr <= vf;
      vs <= vr;
      vd <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Unsaturated counts; a zero plane spacing forces the maximum.
      nw_n   <= (cfg.plane_spacing == '0) ? ANGLE_W'(HOP_MAX) : quo1[0][ANGLE_W-1:0];
      ne_n   <= (cfg.plane_spacing == '0) ? ANGLE_W'(HOP_MAX) : quo1[1][ANGLE_W-1:0];
      diff_n <= diff1;

      prod_w <= PROD_W'(nw_n) * PROD_W'(f);
      prod_e <= PROD_W'(ne_n) * PROD_W'(f);
      nw_p   <= nw_n;
      ne_p   <= ne_n;
      diff_p <= diff_n;

      sw_f   <= fold45(prod_w);
      se_f   <= fold45(prod_e);
      lw_f   <= prod_w[LOW_BITS-1:0];
      le_f   <= prod_e[LOW_BITS-1:0];
      nw_f   <= nw_p;
      ne_f   <= ne_p;
      diff_f <= diff_p;

      qw_r   <= quot45(sw_f);
      qe_r   <= quot45(se_f);
      sw_r   <= sw_f;
      se_r   <= se_f;
      lw_r   <= lw_f;
      le_r   <= le_f;
      nw_r   <= nw_f;
      ne_r   <= ne_f;
      diff_r <= diff_f;

      shift_w <= {rem45(sw_r, qw_r), lw_r};
      shift_e <= {rem45(se_r, qe_r), le_r};
      nw_s    <= nw_r;
      ne_s    <= ne_r;
      diff_s  <= diff_r;

      dw_d <= wrap({1'b0, diff_s} + {1'b0, shift_w});
      de_d <= wrap({1'b0, diff_s} + FULL_TURN - {1'b0, shift_e});
      nw_d <= nw_s;
      ne_d <= ne_s;
    end
  end

  // Intra-plane division: up west, up east, down west, down east.
  logic [3:0][DIV_NUM_W-1:0] num2, quo2;
  logic [TURN_W-1:0]         rw, re;
  logic                      v2;
  logic [2*HOP_BITS-1:0]     side2;

  always_comb begin
    rw      = FULL_TURN - {1'b0, dw_d};
    re      = FULL_TURN - {1'b0, de_d};
    num2[0] = {1'b0, dw_d, 1'b0} + DIV_NUM_W'(cfg.slot_spacing);
    num2[1] = {1'b0, de_d, 1'b0} + DIV_NUM_W'(cfg.slot_spacing);
    num2[2] = {rw, 1'b0} + DIV_NUM_W'(cfg.slot_spacing);
    num2[3] = {re, 1'b0} + DIV_NUM_W'(cfg.slot_spacing);
  end

  wmhc_div #(.LANES(4), .SIDE_W(2*HOP_BITS)) u_div_slot (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (vd),
    .num      (num2),
    .den      ({cfg.slot_spacing, 1'b0}),
    .side_in  ({sat(DIV_NUM_W'(nw_d)), sat(DIV_NUM_W'(ne_d))}),
    .out_valid(v2),
    .quo      (quo2),
    .side_out (side2)
  );

  logic zero_slot;
  assign zero_slot = (cfg.slot_spacing == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hops_west       <= side2[2*HOP_BITS-1:HOP_BITS];
      hops_east       <= side2[HOP_BITS-1:0];
      up_after_west   <= zero_slot ? HOP_MAX : sat(quo2[0]);
      up_after_east   <= zero_slot ? HOP_MAX : sat(quo2[1]);
      down_after_west <= zero_slot ? HOP_MAX : sat(quo2[2]);
      down_after_east <= zero_slot ? HOP_MAX : sat(quo2[3]);
    end
  end

  // Saturation checks for zero spacings.
  logic zero_plane, plane_max_ok, slot_max_ok;
  assign zero_plane   = (cfg.plane_spacing == '0);
  assign plane_max_ok = (hops_west == HOP_MAX) && (hops_east == HOP_MAX);
  assign slot_max_ok  = (up_after_west == HOP_MAX) && (down_after_east == HOP_MAX);

  `WMHC_ASSERT_IMP(a_no_pop_on_stall, out_valid && out_stall, !pop, "pop while output stalled")
  `WMHC_ASSERT_IMP(a_plane_max, out_valid && zero_plane, plane_max_ok, "plane hops not saturated")
  `WMHC_ASSERT_IMP(a_slot_max, out_valid && zero_slot, slot_max_ok, "slot hops not saturated")
  `WMHC_ASSERT_NXT(a_drain, out_valid && !out_stall && !v2, !out_valid, "output word repeated")

endmodule

[hw/rtl/walker_min_hop_count_top.sv]
// ----------------------------------------------------------------------------
// walker_min_hop_count_top
// Minimum hop counts between two satellites of a Walker constellation.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake             Word contents
//   input    in_valid / in_stall   src_phase, src_raan, dst_phase, dst_raan
//   output   out_valid / out_stall hops_west, hops_east, up/down per route
//   config   APB (psel, penable)   plane_spacing, slot_spacing, phasing_offset
//
// The block accepts one word every clock cycle while in_stall is low and returns one
// result word per input word, in order, after the input register, queue, inter-plane
// divider, count, product, modulo and delta stages, intra-plane divider and output
// register. Reset is synchronous: it clears the valid flags and queue pointers and
// sets the configuration registers to their defaults. An output stall freezes the
// arithmetic; the input stall rises once queue and input register fill.
//
module walker_min_hop_count_top import wmhc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // Input channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ANGLE_W-1:0]  src_phase,
  input  logic [ANGLE_W-1:0]  src_raan,
  input  logic [ANGLE_W-1:0]  dst_phase,
  input  logic [ANGLE_W-1:0]  dst_raan,
  // Output channel.
  output logic                out_valid,
  input  logic                out_stall,
  output logic [HOP_BITS-1:0] hops_west,
  output logic [HOP_BITS-1:0] hops_east,
  output logic [HOP_BITS-1:0] up_after_west,
  output logic [HOP_BITS-1:0] up_after_east,
  output logic [HOP_BITS-1:0] down_after_west,
  output logic [HOP_BITS-1:0] down_after_east
);

  // Configuration registers. Writes land on the access cycle; an address
  // beyond the register list is ignored and reads back as zero.
  cfg_t cfg;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.plane_spacing  <= 16'd1920;
      cfg.slot_spacing   <= 16'd2880;
      cfg.phasing_offset <= 16'd0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_PLANE_SPACING:  cfg.plane_spacing  <= pwdata[ANGLE_W-1:0];
        REG_SLOT_SPACING:   cfg.slot_spacing   <= pwdata[ANGLE_W-1:0];
        REG_PHASING_OFFSET: cfg.phasing_offset <= pwdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PLANE_SPACING:  prdata = {16'd0, cfg.plane_spacing};
      REG_SLOT_SPACING:   prdata = {16'd0, cfg.slot_spacing};
      REG_PHASING_OFFSET: prdata = {16'd0, cfg.phasing_offset};
      default:            prdata = '0;
    endcase
  end

  // The front end wraps the angles and forms the distances; the queue lets
  // it keep accepting words while the arithmetic pipeline is held.
  logic  push, q_full, pop, head_valid;
  item_t push_item, head_item;

  wmhc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .src_phase(src_phase),
    .src_raan (src_raan),
    .dst_phase(dst_phase),
    .dst_raan (dst_raan),
    .q_full   (q_full),
    .push     (push),
    .push_item(push_item)
  );

  wmhc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_item (head_item)
  );

  wmhc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .head_valid     (head_valid),
    .head_item      (head_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hops_west      (hops_west),
    .hops_east      (hops_east),
    .up_after_west  (up_after_west),
    .up_after_east  (up_after_east),
    .down_after_west(down_after_west),
    .down_after_east(down_after_east)
  );

endmodule
